// ----- sv/bgd_pkg.sv -----
package bgd_pkg;

    // frame size limits and derived widths
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 13;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 12;
    localparam int SUM_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int OUT_DATA_W = 48;

    // smallest legal frame dimension
    localparam logic [SIZE_W-1:0] MIN_SIZE    = SIZE_W'(4);
    localparam logic [SIZE_W-1:0] WIDTH_MAX   = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX  = SIZE_W'(MAX_HEIGHT);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BAYER_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // reciprocal for divide by five, exact for sums up to 5 * 255
    localparam int DIV5_W = 13;
    localparam logic [DIV5_W-1:0] DIV5_MUL = 13'd6554;
    localparam int DIV5_SHIFT = 15;
    localparam int PROD_W = SUM_W + DIV5_W;

    // how green is finished in the last stage
    typedef enum logic [1:0] {
        GREEN_PASS = 2'd0,
        GREEN_DIV4 = 2'd1,
        GREEN_DIV5 = 2'd2
    } green_sel_t;

    // color site of the window centre, {row parity, column parity}
    typedef enum logic [1:0] {
        SITE_G_RED_ROW  = 2'd0,
        SITE_RED        = 2'd1,
        SITE_BLUE       = 2'd2,
        SITE_G_BLUE_ROW = 2'd3
    } site_t;

endpackage

// ----- sv/bayer_gr8_demosaic_core.sv -----
// Demosaic for raw 8-bit Bayer GR frames with a mono pass-through mode. One pixel beat is
// taken on s_* every clock unless stalled, and results leave on m_* from the output
// register; the rate is set by the single line memory, read when a pixel is accepted and
// written back from stage 1, with a bypass for a back-to-back hit on the same column. In
// Bayer mode the output is the window centre one row and one column behind the input, so no
// result comes for input in row 0 or column 0; border centres come out with written low and
// black color. After reset s_tready stays low while all 4096 line memory words are cleared
// (configuration writes are still taken). Configure only while the block is idle.
module bayer_gr8_demosaic_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [bgd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bgd_pkg::SIZE_W-1:0]     cfg_data,
    // pixel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] raw_pixel
    input  logic                          s_tuser,   // [0] frame_start
    // pixel output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bgd_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] blue, [15:8] green,
                                                     // [23:16] red, [35:24] out_row,
                                                     // [47:36] out_col
    output logic                          m_tuser,   // [0] written
    output logic                          m_tlast    // frame_end
);
    import bgd_pkg::*;

    // configuration
    logic              mode_reg;
    logic [SIZE_W-1:0] w_reg;
    logic [SIZE_W-1:0] h_reg;
    logic [SIZE_W-1:0] cfg_clamp_w;
    logic [SIZE_W-1:0] cfg_clamp_h;

    // position and clearing
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              clearing_reg;
    logic [COL_W-1:0]  clr_cnt_reg;

    // handshake
    logic              adv;
    logic              accept;
    logic [COL_W-1:0]  col_sel;
    logic [ROW_W-1:0]  row_sel;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] row_inc;

    // line memory: [15:8] two rows back, [7:0] one row back
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] mem_q_reg;
    logic               mem_we;
    logic [COL_W-1:0]   mem_waddr;
    logic [2*PIX_W-1:0] mem_wdata;
    logic               lw_vld_reg;
    logic [COL_W-1:0]   lw_addr_reg;
    logic [2*PIX_W-1:0] lw_data_reg;

    // stage 1
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [PIX_W-1:0]  s1_raw_reg;
    logic [PIX_W-1:0]  win_reg [6];
    logic [2*PIX_W-1:0] s1_lines;
    logic [PIX_W-1:0]  top, mid;
    logic              s1_emit;
    logic              s1_written;
    logic              s1_fend;
    logic [POS_W-1:0]  s1_out_row, s1_out_col;
    logic [ROW_W-1:0]  cr;
    logic [COL_W-1:0]  cc;
    site_t             site;
    logic [9:0]        diag, cross_sum;
    logic [8:0]        pair_h, pair_v;
    logic [SUM_W-1:0]  g_num;
    green_sel_t        g_sel;
    logic [PIX_W-1:0]  b_val, r_val;

    // stage 2
    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_gnum_reg;
    green_sel_t        s2_gsel_reg;
    logic [PIX_W-1:0]  s2_blue_reg, s2_red_reg;
    logic [POS_W-1:0]  s2_row_reg, s2_col_reg;
    logic              s2_written_reg, s2_fend_reg;
    logic [PROD_W-1:0] g_prod;
    logic [PIX_W-1:0]  g_val;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_last_reg;

    // clamp sizes on the way into the registers
    always_comb
    begin
        if (cfg_data < MIN_SIZE)
            cfg_clamp_w = MIN_SIZE;
        else if (cfg_data > WIDTH_MAX)
            cfg_clamp_w = WIDTH_MAX;
        else
            cfg_clamp_w = cfg_data;
        if (cfg_data < MIN_SIZE)
            cfg_clamp_h = MIN_SIZE;
        else if (cfg_data > HEIGHT_MAX)
            cfg_clamp_h = HEIGHT_MAX;
        else
            cfg_clamp_h = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            w_reg    <= WIDTH_MAX;
            h_reg    <= HEIGHT_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BAYER_MODE:   mode_reg <= cfg_data[0];
                REG_FRAME_WIDTH:  w_reg    <= cfg_clamp_w;
                REG_FRAME_HEIGHT: h_reg    <= cfg_clamp_h;
                default:          ;
            endcase
        end
    end

    // pipeline moves as a whole when the output register can take a beat
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    // position of the accepted pixel and of the next one
    always_comb
    begin
        col_sel = s_tuser ? '0 : col_reg;
        row_sel = s_tuser ? '0 : row_reg;
        col_inc = SIZE_W'(col_sel) + SIZE_W'(1);
        row_inc = SIZE_W'(row_sel) + SIZE_W'(1);
        if (col_inc >= w_reg)
        begin
            col_next = '0;
            row_next = (row_inc >= h_reg) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // zero the line memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
            if (clr_cnt_reg == '1)
                clearing_reg <= 1'b0;
        end
    end

    // memory write port: clearing pass or stage 1 write-back
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = adv && s1_valid_reg;
            mem_waddr = s1_col_reg;
            mem_wdata = {mid, s1_raw_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_waddr] <= mem_wdata;
        if (accept)
            mem_q_reg <= line_mem[col_sel];
    end

    // last write-back, for a read that overlaps it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lw_vld_reg <= 1'b0;
        else if (adv && s1_valid_reg)
            lw_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            lw_addr_reg <= s1_col_reg;
            lw_data_reg <= {mid, s1_raw_reg};
        end
    end

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_sel;
            s1_row_reg <= row_sel;
            s1_raw_reg <= s_tdata;
        end
    end

    // line data with bypass
    always_comb
    begin
        s1_lines = (lw_vld_reg && lw_addr_reg == s1_col_reg) ? lw_data_reg : mem_q_reg;
        top      = s1_lines[2*PIX_W-1:PIX_W];
        mid      = s1_lines[PIX_W-1:0];
    end

    // window: 0..2 previous column, 3..5 the column before
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top;
            win_reg[1] <= mid;
            win_reg[2] <= s1_raw_reg;
        end
    end

    // centre class and neighbor sums
    always_comb
    begin
        cr        = s1_row_reg - ROW_W'(1);
        cc        = s1_col_reg - COL_W'(1);
        site      = site_t'({cr[0], cc[0]});
        diag      = 10'(win_reg[3]) + 10'(top) + 10'(win_reg[5]) + 10'(s1_raw_reg);
        cross_sum = 10'(win_reg[4]) + 10'(mid) + 10'(win_reg[0]) + 10'(win_reg[2]);
        pair_h    = 9'(win_reg[4]) + 9'(mid);
        pair_v    = 9'(win_reg[0]) + 9'(win_reg[2]);
        s1_fend   = (SIZE_W'(s1_row_reg) + SIZE_W'(1) == h_reg)
                 && (SIZE_W'(s1_col_reg) + SIZE_W'(1) == w_reg);
    end

    // result selection
    always_comb
    begin
        g_sel = GREEN_PASS;
        g_num = '0;
        b_val = '0;
        r_val = '0;
        if (!mode_reg)
        begin
            s1_emit    = 1'b1;
            s1_written = 1'b1;
            s1_out_row = s1_row_reg;
            s1_out_col = s1_col_reg;
            g_num      = SUM_W'(s1_raw_reg);
            b_val      = s1_raw_reg;
            r_val      = s1_raw_reg;
        end
        else
        begin
            s1_emit    = (s1_row_reg != '0) && (s1_col_reg != '0);
            s1_written = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2))
                      && (SIZE_W'(s1_row_reg) + SIZE_W'(2) <= h_reg)
                      && (SIZE_W'(s1_col_reg) + SIZE_W'(2) <= w_reg);
            s1_out_row = cr;
            s1_out_col = cc;
            if (s1_written)
            begin
                case (site)
                    SITE_G_RED_ROW:
                    begin
                        g_sel = GREEN_DIV5;
                        g_num = SUM_W'(win_reg[1]) + SUM_W'(diag);
                        r_val = pair_h[8:1];
                        b_val = pair_v[8:1];
                    end
                    SITE_RED:
                    begin
                        g_sel = GREEN_DIV4;
                        g_num = SUM_W'(cross_sum);
                        r_val = win_reg[1];
                        b_val = diag[9:2];
                    end
                    SITE_BLUE:
                    begin
                        g_sel = GREEN_DIV4;
                        g_num = SUM_W'(cross_sum);
                        b_val = win_reg[1];
                        r_val = diag[9:2];
                    end
                    SITE_G_BLUE_ROW:
                    begin
                        g_sel = GREEN_DIV5;
                        g_num = SUM_W'(win_reg[1]) + SUM_W'(diag);
                        b_val = pair_h[8:1];
                        r_val = pair_v[8:1];
                    end
                    default:
                    begin
                        g_sel = GREEN_PASS;
                        g_num = '0;
                    end
                endcase
            end
        end
    end

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg && s1_emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_gnum_reg    <= g_num;
            s2_gsel_reg    <= g_sel;
            s2_blue_reg    <= b_val;
            s2_red_reg     <= r_val;
            s2_row_reg     <= s1_out_row;
            s2_col_reg     <= s1_out_col;
            s2_written_reg <= s1_written;
            s2_fend_reg    <= s1_fend;
        end
    end

    // finish green: divide by five through the reciprocal
    always_comb
    begin
        g_prod = PROD_W'(s2_gnum_reg) * PROD_W'(DIV5_MUL);
        case (s2_gsel_reg)
            GREEN_PASS: g_val = s2_gnum_reg[PIX_W-1:0];
            GREEN_DIV4: g_val = s2_gnum_reg[PIX_W+1:2];
            GREEN_DIV5: g_val = g_prod[DIV5_SHIFT+PIX_W-1:DIV5_SHIFT];
            default:    g_val = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {s2_col_reg, s2_row_reg, s2_red_reg, g_val, s2_blue_reg};
            out_user_reg <= s2_written_reg;
            out_last_reg <= s2_fend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // no pixel enters while the line memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> !s_tready)
        else $error("pixel accepted during line memory clear");

    // nothing in flight during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> !s1_valid_reg)
        else $error("write-back overlaps line memory clear");

    // the column stays inside the row after each pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we) |=> (SIZE_W'(col_reg) < w_reg))
        else $error("column left the row");

endmodule
